// ----- rtl/xtea_pkg.sv -----
// Shared types, constants and round functions for the XTEA variant block decryptor.
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

   // Width of the configuration register index.
   localparam int CsrAddrWidth = 3;

   // Configuration register indexes.
   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_KEY_WORD_0     = 3'd0,
      CSR_KEY_WORD_1     = 3'd1,
      CSR_KEY_WORD_2     = 3'd2,
      CSR_KEY_WORD_3     = 3'd3,
      CSR_CIPHER_VARIANT = 3'd4
   } csr_index_type;

   // Cipher variant codes.
   localparam logic [1:0] VARIANT_0 = 2'd0;
   localparam logic [1:0] VARIANT_1 = 2'd1;
   localparam logic [1:0] VARIANT_2 = 2'd2;
   localparam logic [1:0] VARIANT_3 = 2'd3;

   typedef logic [31:0]      word_type;
   typedef logic [3:0][31:0] key_type;

   // Per-variant delta constants, variant 0 in the lowest slot.
   localparam key_type DELTA_TAB = {32'hBB67AE85, 32'h6A09E667, 32'h7F4A7C15, 32'h9E3779B9};

   // Per-variant round counts before saturation.
   localparam int COUNT_TAB [4] = '{32, 36, 40, 44};

   // Round count of a variant, saturated at max_rounds, the number of rounds the pipeline holds.
   function automatic int round_count(input int variant, input int max_rounds);
      int count;
      count = COUNT_TAB[variant];
      return (count > max_rounds) ? max_rounds : count;
   endfunction

   // Starting value of the running sum: delta times the round count.
   function automatic word_type start_sum(input int variant, input int max_rounds);
      longint prod;
      prod = longint'(DELTA_TAB[variant]) * longint'(round_count(variant, max_rounds));
      return prod[31:0];
   endfunction

   // Variant-dependent mixing of one data word.
   function automatic word_type mix(input word_type x, input logic [1:0] variant);
      word_type m;
      case (variant)
         VARIANT_0: m = ((x << 4) ^ (x >> 5)) + x;
         VARIANT_1: m = ((x << 5) ^ (x >> 3)) + {x[30:0], x[31]};
         VARIANT_2: m = {x[27:0], x[31:28]} + (x ^ (x >> 7));
         VARIANT_3: m = ({x[28:0], x[31:29]} ^ {x[5:0], x[31:6]}) + x;
         default:   m = x;
      endcase
      return m;
   endfunction

   // Key word picked by a 2-bit index.
   function automatic word_type key_sel(input key_type keys, input logic [1:0] idx);
      return keys[idx];
   endfunction

endpackage : xtea_pkg

`default_nettype wire

// ----- rtl/xtea_variant_block_decrypt.sv -----
// Top level of the XTEA variant block decryptor: one half-round per pipeline stage.
// One block is accepted per cycle while the pipeline advances; the stage count is set by the unrolled half-rounds,
// and rounds beyond the selected variant's count pass the data through unchanged.
// The whole pipeline, bubbles included, holds while a result waits at the output.
// Synchronous reset clears all stage valid bits, the key words and the variant to zero.
`timescale 1ns / 1ps
`default_nettype none

module xtea_variant_block_decrypt #(
   parameter int MAX_ROUNDS = 44
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration write port.
   input  wire logic                              csr_we,
   input  wire logic [xtea_pkg::CsrAddrWidth-1:0] csr_addr,
   input  wire logic [31:0]                       csr_wdata,
   // Ciphertext input stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [63:0]                       req_tdata,  // cipher_right, cipher_left
   // Plaintext result stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [63:0]                            rsp_tdata   // plain_right, plain_left
);
   import xtea_pkg::*;

   localparam int NumStages  = 2 * MAX_ROUNDS;
   localparam int RoundWidth = $clog2(MAX_ROUNDS + 1);

   // Saturated round counts and starting sums, worked out at elaboration.
   localparam logic [3:0][RoundWidth-1:0] ROUND_TAB = {
      RoundWidth'(round_count(3, MAX_ROUNDS)), RoundWidth'(round_count(2, MAX_ROUNDS)),
      RoundWidth'(round_count(1, MAX_ROUNDS)), RoundWidth'(round_count(0, MAX_ROUNDS))};
   localparam key_type START_TAB = {
      start_sum(3, MAX_ROUNDS), start_sum(2, MAX_ROUNDS),
      start_sum(1, MAX_ROUNDS), start_sum(0, MAX_ROUNDS)};

   // Configuration registers.
   key_type    keys_ff;
   logic [1:0] variant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff    <= '0;
         variant_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_KEY_WORD_0:     keys_ff[0] <= csr_wdata;
            CSR_KEY_WORD_1:     keys_ff[1] <= csr_wdata;
            CSR_KEY_WORD_2:     keys_ff[2] <= csr_wdata;
            CSR_KEY_WORD_3:     keys_ff[3] <= csr_wdata;
            CSR_CIPHER_VARIANT: variant_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Values derived from the variant and used by the stages.
   logic [RoundWidth-1:0] round_limit;
   word_type              delta;
   word_type              sum_start;
   logic [1:0]            idx_even;

   assign round_limit = ROUND_TAB[variant_ff];
   assign delta       = DELTA_TAB[variant_ff];
   assign sum_start   = START_TAB[variant_ff];
   assign idx_even    = variant_ff + 2'd1;

   // Pipeline registers; stage k holds the block after half-round k.
   logic     valid_ff [NumStages];
   word_type left_ff  [NumStages];
   word_type right_ff [NumStages];
   word_type sum_ff   [NumStages];

   // The pipeline moves whenever the output stage is empty or being taken.
   logic advance;
   assign advance    = !valid_ff[NumStages-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[NumStages-1];
   assign rsp_tdata  = {right_ff[NumStages-1], left_ff[NumStages-1]};

   for (genvar k = 0; k < NumStages; k++) begin : g_stage
      localparam int Rnd = k / 2;

      logic     valid_src;
      word_type left_src;
      word_type right_src;
      word_type sum_src;
      word_type left_in;
      word_type right_in;
      word_type sum_in;
      word_type mixed;
      word_type keyed;
      logic     active;

      // Stage source: the input stream for the first stage, else the previous stage.
      if (k == 0) begin : g_first
         assign valid_src = req_tvalid;
         assign left_src  = req_tdata[31:0];
         assign right_src = req_tdata[63:32];
         assign sum_src   = sum_start;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign left_src  = left_ff[k-1];
         assign right_src = right_ff[k-1];
         assign sum_src   = sum_ff[k-1];
      end

      assign active = RoundWidth'(Rnd) < round_limit;

      // One half-round: the first half updates right and the sum, the second updates left.
      if (k % 2 == 0) begin : g_half_right
         always_comb begin
            mixed    = mix(left_src, variant_ff);
            keyed    = sum_src + key_sel(keys_ff, sum_src[12:11] ^ idx_even);
            left_in  = left_src;
            right_in = active ? right_src - (mixed ^ keyed) : right_src;
            sum_in   = active ? sum_src - delta : sum_src;
         end
      end else begin : g_half_left
         always_comb begin
            mixed    = mix(right_src, variant_ff);
            keyed    = sum_src + key_sel(keys_ff, sum_src[1:0] ^ variant_ff);
            left_in  = active ? left_src - (mixed ^ keyed) : left_src;
            right_in = right_src;
            sum_in   = sum_src;
         end
      end

      // Valid bit is control state; the data words need no reset.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            left_ff[k]  <= left_in;
            right_ff[k] <= right_in;
            sum_ff[k]   <= sum_in;
         end
      end
   end

endmodule : xtea_variant_block_decrypt

`default_nettype wire
